/* rtl/dht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_pkg: shared definitions for the double hashing table
// Widths, table geometry, result codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dht_pkg;

  // Table geometry.
  localparam int SLOT_COUNT = 101;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Secondary hash: the probe step is STEP_BASE minus (key mod STEP_BASE).
  localparam int STEP_BASE  = 7;
  localparam int STEP_W     = $clog2(STEP_BASE + 1);

  // Item fields.
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = KEY_W + VAL_W;

  // Remainder unit: the key is consumed a few bits per cycle, most significant first.
  localparam int HASH_BPC   = 4;
  localparam int HASH_BITS  = ((KEY_W + HASH_BPC - 1) / HASH_BPC) * HASH_BPC;
  localparam int HASH_CYC   = HASH_BITS / HASH_BPC;
  localparam int HCNT_W     = (HASH_CYC > 1) ? $clog2(HASH_CYC) : 1;

  // Request kinds.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Result codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                hash_en;
    logic                seed;
    logic                rd_en;
    logic                advance;
    logic                wr_en;
    logic                res_en;
    logic [STATUS_W-1:0] res_status;
    logic                res_take_val;
    logic                out_load;
  } dht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic used;
    logic key_hit;
    logic is_search;
    logic last_probe;
    logic out_free;
  } dht_sts_t;

endpackage

/* rtl/dht_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_mod: multi-cycle key remainder unit
// Computes key mod SLOT_COUNT and key mod STEP_BASE, a few key bits per cycle.
// ----------------------------------------------------------------------------
module dht_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       en,
  input  logic [dht_pkg::KEY_W-1:0]  key,
  output logic                       done,
  output logic [dht_pkg::IDX_W-1:0]  rem_tbl,
  output logic [dht_pkg::STEP_W-1:0] rem_step
);
  import dht_pkg::*;

  logic [HASH_BITS-1:0] sh_r;
  logic [IDX_W-1:0]     rem_tbl_r;
  logic [IDX_W-1:0]     rem_tbl_nxt;
  logic [STEP_W-1:0]    rem_step_r;
  logic [STEP_W-1:0]    rem_step_nxt;
  logic [HCNT_W-1:0]    cnt_r;

  // Binary long division: remainder doubles, takes in one bit, and one
  // conditional subtract keeps it below the modulus.
  always_comb begin
    logic [IDX_W:0]  t_tbl;
    logic [STEP_W:0] t_step;
    rem_tbl_nxt  = rem_tbl_r;
    rem_step_nxt = rem_step_r;
    for (int i = 0; i < HASH_BPC; i++) begin
      t_tbl  = {rem_tbl_nxt, sh_r[HASH_BITS-1-i]};
      t_step = {rem_step_nxt, sh_r[HASH_BITS-1-i]};
      if (t_tbl >= (IDX_W+1)'(SLOT_COUNT)) begin
        t_tbl = t_tbl - (IDX_W+1)'(SLOT_COUNT);
      end
      if (t_step >= (STEP_W+1)'(STEP_BASE)) begin
        t_step = t_step - (STEP_W+1)'(STEP_BASE);
      end
      rem_tbl_nxt  = t_tbl[IDX_W-1:0];
      rem_step_nxt = t_step[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_r + HCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r       <= HASH_BITS'(key);
      rem_tbl_r  <= '0;
      rem_step_r <= '0;
    end else if (en) begin
      sh_r       <= sh_r << HASH_BPC;
      rem_tbl_r  <= rem_tbl_nxt;
      rem_step_r <= rem_step_nxt;
    end
  end

  assign done     = en && (cnt_r == HCNT_W'(HASH_CYC - 1));
  assign rem_tbl  = rem_tbl_r;
  assign rem_step = rem_step_r;

endmodule

/* rtl/dht_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_dp: datapath of the double hashing table
// Request registers, slot memory, occupied bits, probe index and result words.
// ----------------------------------------------------------------------------
module dht_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dht_pkg::dht_cmd_t            cmd,
  output dht_pkg::dht_sts_t            sts,
  input  logic                         in_mode,
  input  logic [dht_pkg::KEY_W-1:0]    in_key,
  input  logic [dht_pkg::VAL_W-1:0]    in_value,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [dht_pkg::STATUS_W-1:0] out_status,
  output logic [dht_pkg::VAL_W-1:0]    out_value
);
  import dht_pkg::*;

  logic                 mode_r;
  logic [KEY_W-1:0]     key_r;
  logic [VAL_W-1:0]     val_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic [STEP_W-1:0]    step_r;
  logic [CNT_W-1:0]     probe_cnt_r;
  logic [ENTRY_W-1:0]   slot_mem [SLOT_COUNT];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [SLOT_COUNT-1:0] used_r;
  logic                 used_rd_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [VAL_W-1:0]     res_value_r;
  logic                 out_tvalid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [VAL_W-1:0]     out_value_r;
  logic                 hash_done;
  logic [IDX_W-1:0]     rem_tbl;
  logic [STEP_W-1:0]    rem_step;
  logic [IDX_W:0]       idx_sum;

  dht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .en       (cmd.hash_en),
    .key      (in_key),
    .done     (hash_done),
    .rem_tbl  (rem_tbl),
    .rem_step (rem_step)
  );

  // Next probe slot; the step is below the table size, so one subtract wraps it.
  always_comb begin
    idx_sum = {1'b0, idx_r} + (IDX_W+1)'(step_r);
    if (idx_sum >= (IDX_W+1)'(SLOT_COUNT)) begin
      idx_sum = idx_sum - (IDX_W+1)'(SLOT_COUNT);
    end
    idx_nxt = idx_sum[IDX_W-1:0];
  end

  // Request and probe registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_value;
    end
    if (cmd.seed) begin
      idx_r       <= rem_tbl;
      step_r      <= STEP_W'(STEP_BASE) - rem_step;
      probe_cnt_r <= '0;
    end else if (cmd.advance) begin
      idx_r       <= idx_nxt;
      probe_cnt_r <= probe_cnt_r + CNT_W'(1);
    end
    if (cmd.res_en) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= cmd.res_take_val ? rd_data_r[VAL_W-1:0] : '0;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      slot_mem[idx_r] <= {key_r, val_r};
    end
    if (cmd.rd_en) begin
      rd_data_r <= slot_mem[idx_r];
    end
  end

  // Occupied bits, cleared together at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.wr_en) begin
      used_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      used_rd_r <= used_r[idx_r];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign sts.hash_done  = hash_done;
  assign sts.used       = used_rd_r;
  assign sts.key_hit    = (rd_data_r[ENTRY_W-1:VAL_W] == key_r);
  assign sts.is_search  = (mode_r == MODE_SEARCH);
  assign sts.last_probe = (probe_cnt_r == CNT_W'(SLOT_COUNT - 1));
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  // A write marks its slot occupied.
  a_wr_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |=> used_r[$past(idx_r)])
    else $error("written slot not marked occupied");

endmodule

/* rtl/dht_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_ctrl: controller of the double hashing table
// Sequences hashing, probe reads, slot decisions and result delivery.
// ----------------------------------------------------------------------------
module dht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dht_pkg::dht_sts_t sts,
  output dht_pkg::dht_cmd_t cmd
);
  import dht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SEED,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_en = 1'b1;
        if (sts.hash_done) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // An empty slot ends the walk before any key compare.
        priority if (!sts.used) begin
          cmd.res_en     = 1'b1;
          cmd.wr_en      = !sts.is_search;
          cmd.res_status = sts.is_search ? ST_MISSING : ST_INSERTED;
          state_nxt      = S_EMIT;
        end else if (sts.key_hit) begin
          cmd.res_en       = 1'b1;
          cmd.wr_en        = !sts.is_search;
          cmd.res_take_val = sts.is_search;
          cmd.res_status   = sts.is_search ? ST_FOUND : ST_UPDATED;
          state_nxt        = S_EMIT;
        end else if (sts.last_probe) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = sts.is_search ? ST_MISSING : ST_FULL;
          state_nxt      = S_EMIT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken word");

  a_search_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !sts.is_search)
    else $error("search request wrote the table");

  a_advance_cond: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (sts.used && !sts.key_hit && !sts.last_probe))
    else $error("probe advanced past an ending slot");

  a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |=> (state_r == S_READ || state_r == S_EMIT))
    else $error("slot check left to an unexpected state");

endmodule

/* rtl/double_hash_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_unit: open-addressing key/value table with double hashing
// Inserts, updates and searches 31-bit keys with 32-bit values in a table of
// SLOT_COUNT slots, probing from key mod SLOT_COUNT by 7 - (key mod 7).
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Words carried
//   --------+-----------+---------------------------------------------------
//   in_     | slave     | one request word: mode, key, value
//   out_    | master    | one result word per request: status, value_out
//
// A request walks through accept, remainder steps at four key bits each, one seed step,
// then per probe a registered slot read and then the decision (1 to SLOT_COUNT probes),
// and last the emit step.
// Reset clears the occupied bits of all slots at once; no clearing pass runs.
// A new request is taken once the result moves to the output register, even while that
// word waits; a stalled output holds the block only when the next result is ready too.
module double_hash_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [30:0] key, [62:31] value, [63] zero
  input  logic [0:0]  in_tuser,   // [0] mode: 0 insert or update, 1 search
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic [2:0]  out_tuser   // [2:0] status
);
  import dht_pkg::*;

  dht_cmd_t cmd;
  dht_sts_t sts;

  // Control: one state machine walks each request through hash, probe and emit.
  dht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Data: remainder unit, slot memory, occupied bits and the output register.
  dht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tuser[0]),
    .in_key     (in_tdata[KEY_W-1:0]),
    .in_value   (in_tdata[KEY_W+VAL_W-1:KEY_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (out_tuser),
    .out_value  (out_tdata)
  );

endmodule
